@@ src/dwr_pkg.sv @@
`default_nettype none
package dwr_pkg;

   typedef struct packed {
      logic       command;
      logic [9:0] column;
      logic [4:0] cell_x;
      logic [4:0] cell_y;
      logic       cell_is_wall;
   } req_type;

   typedef struct packed {
      logic [9:0]  column_out;
      logic        wall_hit;
      logic        side;
      logic [1:0]  facing;
      logic [19:0] wall_distance;
      logic [15:0] line_height;
      logic [9:0]  draw_start;
      logic [9:0]  draw_end;
      logic [5:0]  texture_column;
   } rsp_type;

   typedef struct packed {
      logic        is_cast;
      logic [9:0]  column;
      logic [4:0]  cell_x;
      logic [4:0]  cell_y;
      logic        wall;
   } job_type;

   typedef struct packed {
      logic [16:0]        pos_x;
      logic [16:0]        pos_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] plane_x;
      logic signed [15:0] plane_y;
      logic [10:0]        width;
      logic [10:0]        height;
   } cfg_type;

   localparam logic CMD_MAP_WRITE = 1'b0;
   localparam logic CMD_CAST      = 1'b1;

   localparam logic [1:0] FACE_Y_POS = 2'd0;
   localparam logic [1:0] FACE_X_NEG = 2'd1;
   localparam logic [1:0] FACE_Y_NEG = 2'd2;
   localparam logic [1:0] FACE_X_POS = 2'd3;

   localparam logic [2:0] REG_POS_X   = 3'd0;
   localparam logic [2:0] REG_POS_Y   = 3'd1;
   localparam logic [2:0] REG_DIR_X   = 3'd2;
   localparam logic [2:0] REG_DIR_Y   = 3'd3;
   localparam logic [2:0] REG_PLANE_X = 3'd4;
   localparam logic [2:0] REG_PLANE_Y = 3'd5;
   localparam logic [2:0] REG_WIDTH   = 3'd6;
   localparam logic [2:0] REG_HEIGHT  = 3'd7;

   localparam logic [16:0] RST_POS_X   = 17'd8192;
   localparam logic [16:0] RST_POS_Y   = 17'd8192;
   localparam logic [15:0] RST_DIR_X   = 16'hC000;
   localparam logic [15:0] RST_DIR_Y   = 16'd0;
   localparam logic [15:0] RST_PLANE_X = 16'd0;
   localparam logic [15:0] RST_PLANE_Y = 16'd10813;
   localparam logic [10:0] RST_WIDTH   = 11'd640;
   localparam logic [10:0] RST_HEIGHT  = 11'd480;

   localparam int TEX_W       = 64;
   localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

@@ src/dwr_div.sv @@
`default_nettype none
module dwr_div #(
   parameter int NW = 47,
   parameter int DW = 28
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quo,
   output logic [DW-1:0]      rem
);

   localparam int CNTW = $clog2(NW + 1);

   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]   q_ff, q_in;
   logic [DW-1:0]   acc_ff, acc_in;
   logic            done_ff, done_in;
   logic [DW:0]     trial;
   logic [DW:0]     diff;
   logic            ge;

   always_comb begin
      trial   = {acc_ff, q_ff[NW-1]};
      diff    = trial - {1'b0, den};
      ge      = trial >= {1'b0, den};
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNTW'(NW);
         q_in   = num;
         acc_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CNTW'(1);
         q_in    = {q_ff[NW-2:0], ge};
         acc_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
         done_in = cnt_ff == CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign rem  = acc_ff;

endmodule
`default_nettype wire

@@ src/dwr_front.sv @@
`default_nettype none
module dwr_front #(
   parameter int MAP_W = 32,
   parameter int MAP_H = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dwr_pkg::req_type req_word,
   input  wire logic             hold,
   input  wire logic             q_full,
   output logic                  full,
   output logic                  q_push,
   output dwr_pkg::job_type      q_word
);

   logic             valid_ff, valid_in;
   dwr_pkg::req_type item_ff, item_in;
   logic             keep;
   logic             accept;

   always_comb begin
      keep = (item_ff.command == dwr_pkg::CMD_CAST)
          || ((32'(item_ff.cell_x) < MAP_W) && (32'(item_ff.cell_y) < MAP_H));
      full   = hold || (valid_ff && q_full && keep);
      accept = push && !full;
      q_push = valid_ff && keep && !q_full;
      q_word.is_cast = item_ff.command == dwr_pkg::CMD_CAST;
      q_word.column  = item_ff.column;
      q_word.cell_x  = item_ff.cell_x;
      q_word.cell_y  = item_ff.cell_y;
      q_word.wall    = item_ff.cell_is_wall;
      valid_in = valid_ff;
      item_in  = item_ff;
      if (valid_ff && (!keep || !q_full)) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         item_in  = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule
`default_nettype wire

@@ src/dwr_queue.sv @@
`default_nettype none
module dwr_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire dwr_pkg::job_type wr_word,
   output logic                  full,
   output logic                  valid,
   input  wire logic             rd_en,
   output dwr_pkg::job_type      rd_word
);

   localparam int D  = dwr_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(D);

   dwr_pkg::job_type  slot_ff [D];
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]       cnt_ff, cnt_in;
   logic              do_wr, do_rd;

   always_comb begin
      full    = cnt_ff == (PW+1)'(D);
      valid   = cnt_ff != '0;
      rd_word = slot_ff[rp_ff];
      do_wr   = wr_en && !full;
      do_rd   = rd_en && valid;
      wp_in   = do_wr ? wp_ff + PW'(1) : wp_ff;
      rp_in   = do_rd ? rp_ff + PW'(1) : rp_ff;
      cnt_in  = cnt_ff + (PW+1)'(do_wr) - (PW+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_wr) begin
         slot_ff[wp_ff] <= wr_word;
      end
   end

endmodule
`default_nettype wire

@@ src/dwr_back.sv @@
`default_nettype none
module dwr_back #(
   parameter int MAP_W = 32,
   parameter int MAP_H = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dwr_pkg::cfg_type cfg,
   input  wire logic             job_valid,
   input  wire dwr_pkg::job_type job,
   output logic                  job_pop,
   output logic                  clearing,
   output logic                  empty,
   input  wire logic             pop,
   output dwr_pkg::rsp_type      rsp_word
);

   localparam int DEPTH = MAP_W * MAP_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int STEPS = MAP_W + MAP_H;
   localparam int NSW   = $clog2(STEPS + 1);
   localparam int RW    = 29;
   localparam int AR    = RW - 1;
   localparam int CAMW  = 27;
   localparam int PRW   = 43;
   localparam int LW    = $clog2(STEPS + 2) + 12;
   localparam int PW    = LW + AR;
   localparam int NW    = LW + AR;
   localparam int MW    = $clog2(MAP_W + MAP_H + 32) + 2;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CAM   = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_RAY   = 4'd4;
   localparam logic [3:0] S_INIT  = 4'd5;
   localparam logic [3:0] S_PROD  = 4'd6;
   localparam logic [3:0] S_STEP  = 4'd7;
   localparam logic [3:0] S_CHECK = 4'd8;
   localparam logic [3:0] S_DIST  = 4'd9;
   localparam logic [3:0] S_LINE  = 4'd10;
   localparam logic [3:0] S_TEX   = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0]             state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic                   launched_ff, launched_in;
   logic [9:0]             col_ff, col_in;
   logic signed [CAMW-1:0] cam_ff, cam_in;
   logic signed [PRW-1:0]  prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [RW-1:0]   rdx_ff, rdx_in, rdy_ff, rdy_in;
   logic [AR-1:0]          ax_ff, ax_in, ay_ff, ay_in;
   logic [LW-1:0]          tx_ff, tx_in, ty_ff, ty_in, len_ff, len_in;
   logic [PW-1:0]          px_ff, px_in, py_ff, py_in;
   logic signed [MW-1:0]   mx_ff, mx_in, my_ff, my_in;
   logic [NSW-1:0]         n_ff, n_in;
   logic                   side_ff, side_in, hit_ff, hit_in;
   logic [19:0]            dist_ff, dist_in;
   logic [15:0]            lh_ff, lh_in;
   logic [5:0]             tex_ff, tex_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   dwr_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   map_mem [DEPTH];
   logic                   rd_ff;
   logic                   mem_we, mem_wd;
   logic [AW-1:0]          mem_wa, rd_addr;

   logic                   div_start, div_done;
   logic [NW-1:0]          div_num, div_quo;
   logic [AR-1:0]          div_den, div_rem;

   logic                   step_x, out_of_map, load_rsp, mirror;
   logic signed [MW-1:0]   nmx, nmy;
   logic [AR-1:0]          axis_div, other_abs;
   logic signed [RW-1:0]   other;
   logic [16:0]            base;
   logic [12+AR:0]         init_prod;
   logic [11:0]            qlow, frac;
   logic [31:0]            texp, tex32;
   logic [9:0]             half_h;
   logic [14:0]            half_lh;
   logic signed [17:0]     ds, de;

   dwr_div #(.NW(NW), .DW(AR)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      launched_in  = launched_ff;
      col_in       = col_ff;
      cam_in       = cam_ff;
      prodx_in     = prodx_ff;
      prody_in     = prody_ff;
      rdx_in       = rdx_ff;
      rdy_in       = rdy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      len_in       = len_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      n_in         = n_ff;
      side_in      = side_ff;
      hit_in       = hit_ff;
      dist_in      = dist_ff;
      lh_in        = lh_ff;
      tex_in       = tex_ff;
      rsp_in       = rsp_ff;
      job_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_wd       = 1'b0;
      mem_wa       = AW'(32'(job.cell_y) * MAP_W + 32'(job.cell_x));
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      load_rsp     = 1'b0;

      step_x     = px_ff < py_ff;
      nmx        = step_x ? (rdx_ff[RW-1] ? mx_ff - MW'(1) : mx_ff + MW'(1)) : mx_ff;
      nmy        = step_x ? my_ff : (rdy_ff[RW-1] ? my_ff - MW'(1) : my_ff + MW'(1));
      out_of_map = nmx[MW-1] || nmy[MW-1] || (nmx >= MW'(MAP_W)) || (nmy >= MW'(MAP_H));
      rd_addr    = AW'(32'(nmy) * MAP_W + 32'(nmx));
      init_prod  = {AR'(0), tx_ff[12:0]} * {13'd0, ay_ff};

      axis_div  = side_ff ? ay_ff : ax_ff;
      other     = side_ff ? rdx_ff : rdy_ff;
      other_abs = other[RW-1] ? AR'(-other) : AR'(other);
      base      = side_ff ? cfg.pos_x : cfg.pos_y;
      qlow      = other[RW-1] ? 12'd0 - (div_quo[11:0] + 12'(div_rem != '0)) : div_quo[11:0];
      if (axis_div == '0) begin
         qlow = 12'd0;
      end
      frac   = base[11:0] + qlow;
      texp   = 32'(frac) * 32'(dwr_pkg::TEX_W);
      tex32  = texp >> 12;
      mirror = (!side_ff && !rdx_ff[RW-1] && (rdx_ff != '0)) || (side_ff && rdy_ff[RW-1]);
      if (mirror) begin
         tex32 = 32'(dwr_pkg::TEX_W - 1) - tex32;
      end

      half_h  = cfg.height[10:1];
      half_lh = lh_ff[15:1];
      ds = 18'(half_h) - 18'(half_lh);
      if (ds < 0) begin
         ds = '0;
      end
      if (ds > 18'sd1023) begin
         ds = 18'sd1023;
      end
      de = 18'(half_lh) + 18'(half_h);
      if (de >= 18'(cfg.height)) begin
         de = 18'(cfg.height) - 18'sd1;
      end
      if (de < 0) begin
         de = '0;
      end
      if (de > 18'sd1023) begin
         de = 18'sd1023;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               if (job.is_cast) begin
                  col_in   = job.column;
                  state_in = S_CAM;
               end else begin
                  mem_we = 1'b1;
                  mem_wd = job.wall;
               end
            end
         end
         S_CAM: begin
            div_num = NW'({col_ff, 15'd0});
            div_den = (cfg.width == '0) ? AR'(1) : AR'(cfg.width);
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               launched_in = 1'b0;
               cam_in      = $signed(CAMW'(div_quo)) - CAMW'(16384);
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            prodx_in = PRW'(cfg.plane_x) * PRW'(cam_ff);
            prody_in = PRW'(cfg.plane_y) * PRW'(cam_ff);
            state_in = S_RAY;
         end
         S_RAY: begin
            rdx_in   = RW'(cfg.dir_x) + RW'(prodx_ff >>> 14);
            rdy_in   = RW'(cfg.dir_y) + RW'(prody_ff >>> 14);
            state_in = S_INIT;
         end
         S_INIT: begin
            ax_in = rdx_ff[RW-1] ? AR'(-rdx_ff) : AR'(rdx_ff);
            ay_in = rdy_ff[RW-1] ? AR'(-rdy_ff) : AR'(rdy_ff);
            tx_in = rdx_ff[RW-1] ? LW'(cfg.pos_x[11:0])
                                 : LW'(13'd4096 - {1'b0, cfg.pos_x[11:0]});
            ty_in = rdy_ff[RW-1] ? LW'(cfg.pos_y[11:0])
                                 : LW'(13'd4096 - {1'b0, cfg.pos_y[11:0]});
            mx_in    = MW'(cfg.pos_x[16:12]);
            my_in    = MW'(cfg.pos_y[16:12]);
            n_in     = '0;
            state_in = S_PROD;
         end
         S_PROD: begin
            px_in    = PW'(init_prod);
            init_prod = {AR'(0), ty_ff[12:0]} * {13'd0, ax_ff};
            py_in    = PW'(init_prod);
            state_in = S_STEP;
         end
         S_STEP: begin
            n_in  = n_ff + NSW'(1);
            mx_in = nmx;
            my_in = nmy;
            if (step_x) begin
               len_in  = tx_ff;
               tx_in   = tx_ff + LW'(4096);
               px_in   = px_ff + PW'({ay_ff, 12'd0});
               side_in = 1'b0;
            end else begin
               len_in  = ty_ff;
               ty_in   = ty_ff + LW'(4096);
               py_in   = py_ff + PW'({ax_ff, 12'd0});
               side_in = 1'b1;
            end
            if (out_of_map) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (rd_ff) begin
               hit_in   = 1'b1;
               state_in = S_DIST;
            end else if (n_ff == NSW'(STEPS)) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               state_in = S_STEP;
            end
         end
         S_DIST: begin
            div_num = NW'(len_ff) << 14;
            div_den = axis_div;
            if (axis_div == '0) begin
               dist_in  = 20'hFFFFF;
               state_in = S_LINE;
            end else if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               launched_in = 1'b0;
               dist_in     = (div_quo > NW'(20'hFFFFF)) ? 20'hFFFFF : div_quo[19:0];
               state_in    = S_LINE;
            end
         end
         S_LINE: begin
            div_num = NW'({cfg.height, 12'd0});
            div_den = AR'(dist_ff);
            if (dist_ff == '0) begin
               lh_in    = 16'hFFFF;
               state_in = S_TEX;
            end else if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               launched_in = 1'b0;
               lh_in       = (div_quo > NW'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
               state_in    = S_TEX;
            end
         end
         S_TEX: begin
            div_num = NW'(len_ff) * NW'(other_abs);
            div_den = axis_div;
            if (axis_div == '0) begin
               tex_in   = tex32[5:0];
               state_in = S_DONE;
            end else if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               launched_in = 1'b0;
               tex_in      = tex32[5:0];
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || pop) begin
               load_rsp = 1'b1;
               rsp_in   = '0;
               rsp_in.column_out = col_ff;
               if (hit_ff) begin
                  rsp_in.wall_hit       = 1'b1;
                  rsp_in.side           = side_ff;
                  rsp_in.wall_distance  = dist_ff;
                  rsp_in.line_height    = lh_ff;
                  rsp_in.draw_start     = ds[9:0];
                  rsp_in.draw_end       = de[9:0];
                  rsp_in.texture_column = tex_ff;
                  if (side_ff) begin
                     rsp_in.facing = rdy_ff[RW-1] ? dwr_pkg::FACE_Y_NEG : dwr_pkg::FACE_Y_POS;
                  end else begin
                     rsp_in.facing = rdx_ff[RW-1] ? dwr_pkg::FACE_X_NEG : dwr_pkg::FACE_X_POS;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !pop) || load_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff   <= col_in;
      cam_ff   <= cam_in;
      prodx_ff <= prodx_in;
      prody_ff <= prody_in;
      rdx_ff   <= rdx_in;
      rdy_ff   <= rdy_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      len_ff   <= len_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      n_ff     <= n_in;
      side_ff  <= side_in;
      hit_ff   <= hit_in;
      dist_ff  <= dist_in;
      lh_ff    <= lh_in;
      tex_ff   <= tex_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= map_mem[rd_addr];
   end

   assign clearing = state_ff == S_CLEAR;
   assign empty    = !rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule
`default_nettype wire

@@ src/dda_wall_raycaster.sv @@
// A cast with a wall hit runs up to four divisions and one without runs one, each on the
// shared one-bit-per-cycle divider of width W (47 at a 32x32 map); each DDA step taken
// also waits on a registered map read between S_STEP and S_CHECK.
// A map write is done in the back end's idle state.
// Throughput: one word at a time in the back end; a 4-word queue buffers input.
// Synchronous reset restores the registers and then clears the map while full stays high.
`default_nettype none
module dda_wall_raycaster #(
   parameter int MAP_W = 32,
   parameter int MAP_H = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire dwr_pkg::req_type req_word,
   output logic                  empty,
   input  wire logic             pop,
   output dwr_pkg::rsp_type      rsp_word,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [4:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   dwr_pkg::cfg_type cfg_ff, cfg_in;
   logic             hold, q_full, q_push, q_valid, q_pop;
   dwr_pkg::job_type q_wword, q_rword;
   logic [2:0]       idx;

   assign idx    = paddr[4:2];
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (idx)
            dwr_pkg::REG_POS_X:   cfg_in.pos_x   = pwdata[16:0];
            dwr_pkg::REG_POS_Y:   cfg_in.pos_y   = pwdata[16:0];
            dwr_pkg::REG_DIR_X:   cfg_in.dir_x   = pwdata[15:0];
            dwr_pkg::REG_DIR_Y:   cfg_in.dir_y   = pwdata[15:0];
            dwr_pkg::REG_PLANE_X: cfg_in.plane_x = pwdata[15:0];
            dwr_pkg::REG_PLANE_Y: cfg_in.plane_y = pwdata[15:0];
            dwr_pkg::REG_WIDTH:   cfg_in.width   = pwdata[10:0];
            dwr_pkg::REG_HEIGHT:  cfg_in.height  = pwdata[10:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
      unique case (idx)
         dwr_pkg::REG_POS_X:   prdata = 32'(cfg_ff.pos_x);
         dwr_pkg::REG_POS_Y:   prdata = 32'(cfg_ff.pos_y);
         dwr_pkg::REG_DIR_X:   prdata = 32'(unsigned'(cfg_ff.dir_x));
         dwr_pkg::REG_DIR_Y:   prdata = 32'(unsigned'(cfg_ff.dir_y));
         dwr_pkg::REG_PLANE_X: prdata = 32'(unsigned'(cfg_ff.plane_x));
         dwr_pkg::REG_PLANE_Y: prdata = 32'(unsigned'(cfg_ff.plane_y));
         dwr_pkg::REG_WIDTH:   prdata = 32'(cfg_ff.width);
         dwr_pkg::REG_HEIGHT:  prdata = 32'(cfg_ff.height);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x   <= dwr_pkg::RST_POS_X;
         cfg_ff.pos_y   <= dwr_pkg::RST_POS_Y;
         cfg_ff.dir_x   <= dwr_pkg::RST_DIR_X;
         cfg_ff.dir_y   <= dwr_pkg::RST_DIR_Y;
         cfg_ff.plane_x <= dwr_pkg::RST_PLANE_X;
         cfg_ff.plane_y <= dwr_pkg::RST_PLANE_Y;
         cfg_ff.width   <= dwr_pkg::RST_WIDTH;
         cfg_ff.height  <= dwr_pkg::RST_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dwr_front #(.MAP_W(MAP_W), .MAP_H(MAP_H)) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_word (req_word),
      .hold     (hold),
      .q_full   (q_full),
      .full     (full),
      .q_push   (q_push),
      .q_word   (q_wword)
   );

   dwr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_word (q_wword),
      .full    (q_full),
      .valid   (q_valid),
      .rd_en   (q_pop),
      .rd_word (q_rword)
   );

   dwr_back #(.MAP_W(MAP_W), .MAP_H(MAP_H)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (q_valid),
      .job       (q_rword),
      .job_pop   (q_pop),
      .clearing  (hold),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire
